FILE: design/lsmp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lsmp_pkg
// Types, register indexes, arc-tangent table and rounding helpers shared by
// the laser scan projection block and its CORDIC unit.
// ----------------------------------------------------------------------------
package lsmp_pkg;

    localparam int CORDIC_STEPS = 16;

    typedef logic signed [33:0] t_cdata;   // CORDIC x/y, Q1.30 with headroom
    typedef logic signed [32:0] t_zdata;   // residual angle, turn/2^32
    typedef logic signed [17:0] t_coord;   // x or y in 1/1024 m
    typedef logic        [35:0] t_dist;    // squared distance, 1/2^20 m^2
    typedef logic        [3:0]  t_iter;

    localparam t_cdata CORDIC_GAIN_INV = 34'sd652032874;
    localparam t_dist  REAR_LIMIT_SQ   = 36'd524288;

    // Configuration register indexes.
    localparam logic [7:0] CFG_ANGLE_START  = 8'd0;
    localparam logic [7:0] CFG_ANGLE_STEP   = 8'd1;
    localparam logic [7:0] CFG_RANGE_MIN    = 8'd2;
    localparam logic [7:0] CFG_RANGE_CUTOFF = 8'd3;
    localparam logic [7:0] CFG_MIN_DIST_SQ  = 8'd4;
    localparam logic [7:0] CFG_MAX_DIST_SQ  = 8'd5;
    localparam logic [7:0] CFG_SCALE        = 8'd6;
    localparam logic [7:0] CFG_PRESERVE     = 8'd7;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CORDIC,
        ST_MUL_XC,
        ST_MUL_YS,
        ST_SQ_X,
        ST_SQ_Y,
        ST_SC_X,
        ST_SC_Y,
        ST_FINISH,
        ST_OUT
    } t_state;

    function automatic t_zdata atan_lut(input t_iter i);
        t_zdata v;
        unique case (i)
            4'd0:    v = 33'sh020000000;
            4'd1:    v = 33'sh012E4051E;
            4'd2:    v = 33'sh009FB385B;
            4'd3:    v = 33'sh0051111D4;
            4'd4:    v = 33'sh0028B0D43;
            4'd5:    v = 33'sh00145D7E1;
            4'd6:    v = 33'sh000A2F61E;
            4'd7:    v = 33'sh000517C55;
            4'd8:    v = 33'sh00028BE53;
            4'd9:    v = 33'sh000145F2F;
            4'd10:   v = 33'sh0000A2F98;
            4'd11:   v = 33'sh0000517CC;
            4'd12:   v = 33'sh000028BE6;
            4'd13:   v = 33'sh0000145F3;
            4'd14:   v = 33'sh000000A2FA;
            default: v = 33'sh00000517D;
        endcase
        return v;
    endfunction

    // Round a product of x or y by the Q8.8 scale to Q12.4 cells, saturating.
    function automatic logic [15:0] to_cells(input logic signed [51:0] prod);
        logic signed [51:0] sum;
        logic signed [37:0] p;
        sum = prod + 52'sd8192;
        p   = sum[51:14];
        priority if (p > 38'sd32767) begin
            return 16'h7FFF;
        end else if (p < -38'sd32768) begin
            return 16'h8000;
        end else begin
            return p[15:0];
        end
    endfunction

endpackage
`default_nettype wire

FILE: design/lsmp_cordic.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lsmp_cordic
// Iterative rotation-mode CORDIC: one micro-rotation per cycle, sixteen in
// all, giving gain-compensated cosine and sine in Q1.30 of a 16-bit angle.
// ----------------------------------------------------------------------------
module lsmp_cordic (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_start,
    input  wire logic [15:0]     i_angle,
    output lsmp_pkg::t_cdata     o_cos,
    output lsmp_pkg::t_cdata     o_sin,
    output logic                 o_done
);

    localparam lsmp_pkg::t_iter LAST_ITER = 4'(lsmp_pkg::CORDIC_STEPS - 1);

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    lsmp_pkg::t_iter  r_iter, n_iter;
    lsmp_pkg::t_cdata r_x, n_x, r_y, n_y;
    lsmp_pkg::t_zdata r_z, n_z;

    logic             flip;
    logic [15:0]      ang_rot;
    lsmp_pkg::t_cdata xs, ys;
    lsmp_pkg::t_zdata at;

    always_comb begin
        // Angles in the left half-plane are turned by half a turn and x starts
        // negated, so the iterations only ever cover +/- a quarter turn.
        flip    = i_angle[15] ^ i_angle[14];
        ang_rot = {i_angle[15] ^ flip, i_angle[14:0]};
        xs      = r_x >>> r_iter;
        ys      = r_y >>> r_iter;
        at      = lsmp_pkg::atan_lut(r_iter);

        n_busy = r_busy;
        n_done = 1'b0;
        n_iter = r_iter;
        n_x    = r_x;
        n_y    = r_y;
        n_z    = r_z;

        if (i_start) begin
            n_busy = 1'b1;
            n_iter = '0;
            n_x    = flip ? -lsmp_pkg::CORDIC_GAIN_INV : lsmp_pkg::CORDIC_GAIN_INV;
            n_y    = '0;
            n_z    = $signed({ang_rot[15], ang_rot, 16'h0000});
        end else if (r_busy) begin
            if (!r_z[32]) begin
                n_x = r_x - ys;
                n_y = r_y + xs;
                n_z = r_z - at;
            end else begin
                n_x = r_x + ys;
                n_y = r_y - xs;
                n_z = r_z + at;
            end
            n_iter = 4'(r_iter + 4'd1);
            if (r_iter == LAST_ITER) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_iter <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_iter <= n_iter;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x <= n_x;
        r_y <= n_y;
        r_z <= n_z;
    end

    assign o_cos  = r_x;
    assign o_sin  = r_y;
    assign o_done = r_done;

endmodule
`default_nettype wire

FILE: design/laser_scan_to_map_points.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// laser_scan_to_map_points
// Projects lidar range samples to map-cell coordinates with a shared CORDIC
// and one shared multiplier under a small sequencer.
// ----------------------------------------------------------------------------
// Each accepted word is one range sample; tuser set marks the first beam of a
// scan, which reloads the beam angle from angle_start and clears the beam
// number. A beam rejected by the range gate leaves the block idle and ready
// again at once. A beam that passes occupies the block for the accept step,
// the CORDIC micro-rotations and a step until their end is seen, then six
// passes through a single 34 x 18 bit multiplier (x, y, their squares and the
// two scalings), a decision step and the load of the output register. A beam
// that fails the distance checks skips that load. The result waits in that
// register, so a new beam can be taken while it is still unread; the load of
// the next result waits until the previous word has been read. Beams that
// fail the distance checks produce no word but still advance the angle and
// beam number. Configuration writes are always accepted and should only be
// issued while the block is idle.
// ----------------------------------------------------------------------------
module laser_scan_to_map_points #(
    parameter int MAX_BEAMS = 4096
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Configuration write channel.
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [7:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data,
    // Sample stream in.
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,    // [15:0] range_sample
    input  wire logic        s_axis_tuser,    // [0] first_beam
    // Point stream out.
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [47:0]      m_axis_tdata     // [15:0] map_x, [31:16] map_y,
                                              // [43:32] beam_number, rest zero
);

    // Configuration registers.
    logic [15:0] r_angle_start, r_angle_step, r_range_min, r_range_cutoff;
    logic [31:0] r_min_dist_sq, r_max_dist_sq;
    logic [15:0] r_scale;
    logic        r_preserve;

    // Beam tracking.
    logic [11:0] r_beam_count, n_beam_count;
    logic [15:0] r_beam_angle, n_beam_angle;

    lsmp_pkg::t_state r_state, n_state;

    logic [15:0]        r_range, n_range;
    logic [11:0]        r_idx, n_idx;
    logic signed [51:0] r_prod;
    lsmp_pkg::t_coord   r_x, n_x, r_y, n_y;
    lsmp_pkg::t_dist    r_d2, n_d2;
    logic [15:0]        r_cell_x, n_cell_x, r_cell_y, n_cell_y;
    logic               r_keep, n_keep;

    logic               r_m_valid, n_m_valid;
    logic [15:0]        r_out_x, n_out_x, r_out_y, n_out_y;
    logic [11:0]        r_out_n, n_out_n;

    // Shared multiplier.
    logic signed [33:0] mul_a;
    logic signed [17:0] mul_b;
    logic signed [51:0] mul_p;

    logic               cordic_start;
    logic [15:0]        cordic_angle;
    lsmp_pkg::t_cdata   cordic_cos, cordic_sin;
    logic               cordic_done;

    logic               in_accept;
    logic [12:0]        cnt_inc;
    logic signed [51:0] round_p;
    logic               range_ok;

    lsmp_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cordic_start),
        .i_angle (cordic_angle),
        .o_cos   (cordic_cos),
        .o_sin   (cordic_sin),
        .o_done  (cordic_done)
    );

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_angle_start  <= 16'd0;
            r_angle_step   <= 16'd64;
            r_range_min    <= 16'd102;
            r_range_cutoff <= 16'd6144;
            r_min_dist_sq  <= 32'd10486;
            r_max_dist_sq  <= 32'd943718400;
            r_scale        <= 16'd10240;
            r_preserve     <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                lsmp_pkg::CFG_ANGLE_START:  r_angle_start  <= i_cfg_data[15:0];
                lsmp_pkg::CFG_ANGLE_STEP:   r_angle_step   <= i_cfg_data[15:0];
                lsmp_pkg::CFG_RANGE_MIN:    r_range_min    <= i_cfg_data[15:0];
                lsmp_pkg::CFG_RANGE_CUTOFF: r_range_cutoff <= i_cfg_data[15:0];
                lsmp_pkg::CFG_MIN_DIST_SQ:  r_min_dist_sq  <= i_cfg_data;
                lsmp_pkg::CFG_MAX_DIST_SQ:  r_max_dist_sq  <= i_cfg_data;
                lsmp_pkg::CFG_SCALE:        r_scale        <= i_cfg_data[15:0];
                lsmp_pkg::CFG_PRESERVE:     r_preserve     <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Operand selection for the shared multiplier, by sequencer step.
    always_comb begin
        unique case (r_state)
            lsmp_pkg::ST_MUL_YS: begin
                mul_a = cordic_sin;
                mul_b = $signed({2'b00, r_range});
            end
            lsmp_pkg::ST_SQ_X: begin
                mul_a = $signed({{16{r_x[17]}}, r_x});
                mul_b = r_x;
            end
            lsmp_pkg::ST_SQ_Y: begin
                mul_a = $signed({{16{r_y[17]}}, r_y});
                mul_b = r_y;
            end
            lsmp_pkg::ST_SC_X: begin
                mul_a = $signed({{16{r_x[17]}}, r_x});
                mul_b = $signed({2'b00, r_scale});
            end
            lsmp_pkg::ST_SC_Y: begin
                mul_a = $signed({{16{r_y[17]}}, r_y});
                mul_b = $signed({2'b00, r_scale});
            end
            default: begin
                mul_a = cordic_cos;
                mul_b = $signed({2'b00, r_range});
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    always_comb begin
        in_accept    = s_axis_tvalid && (r_state == lsmp_pkg::ST_IDLE);
        s_axis_tready = (r_state == lsmp_pkg::ST_IDLE);
        // Round r*cos or r*sin from Q1.30 to 1/1024 m.
        round_p      = r_prod + 52'sd536870912;
        cordic_start = 1'b0;
        cordic_angle = s_axis_tuser ? r_angle_start : r_beam_angle;
        cnt_inc      = '0;
        range_ok     = 1'b0;

        n_state      = r_state;
        n_beam_count = r_beam_count;
        n_beam_angle = r_beam_angle;
        n_range      = r_range;
        n_idx        = r_idx;
        n_x          = r_x;
        n_y          = r_y;
        n_d2         = r_d2;
        n_cell_x     = r_cell_x;
        n_cell_y     = r_cell_y;
        n_keep       = r_keep;
        n_m_valid    = r_m_valid && !m_axis_tready;
        n_out_x      = r_out_x;
        n_out_y      = r_out_y;
        n_out_n      = r_out_n;

        unique case (r_state)
            lsmp_pkg::ST_IDLE: begin
                if (in_accept) begin
                    n_idx        = s_axis_tuser ? 12'd0 : r_beam_count;
                    n_range      = s_axis_tdata;
                    n_beam_angle = 16'(cordic_angle + r_angle_step);
                    cnt_inc      = {1'b0, n_idx} + 13'd1;
                    n_beam_count = (int'(cnt_inc) >= MAX_BEAMS) ? 12'd0 : cnt_inc[11:0];
                    range_ok     = r_preserve || (s_axis_tdata < r_range_cutoff &&
                                                  s_axis_tdata >= r_range_min);
                    if (range_ok) begin
                        cordic_start = 1'b1;
                        n_state      = lsmp_pkg::ST_CORDIC;
                    end
                end
            end
            lsmp_pkg::ST_CORDIC: begin
                if (cordic_done) begin
                    n_state = lsmp_pkg::ST_MUL_XC;
                end
            end
            lsmp_pkg::ST_MUL_XC: n_state = lsmp_pkg::ST_MUL_YS;
            lsmp_pkg::ST_MUL_YS: begin
                n_x     = round_p[47:30];
                n_state = lsmp_pkg::ST_SQ_X;
            end
            lsmp_pkg::ST_SQ_X: begin
                n_y     = round_p[47:30];
                n_state = lsmp_pkg::ST_SQ_Y;
            end
            lsmp_pkg::ST_SQ_Y: begin
                n_d2    = r_prod[35:0];
                n_state = lsmp_pkg::ST_SC_X;
            end
            lsmp_pkg::ST_SC_X: begin
                n_d2    = r_d2 + r_prod[35:0];
                n_state = lsmp_pkg::ST_SC_Y;
            end
            lsmp_pkg::ST_SC_Y: begin
                n_cell_x = lsmp_pkg::to_cells(r_prod);
                // Inside the distance window, and not a close point behind.
                n_keep   = (r_d2 > {4'd0, r_min_dist_sq}) &&
                           (r_d2 < {4'd0, r_max_dist_sq}) &&
                           !(r_x[17] && (r_d2 < lsmp_pkg::REAR_LIMIT_SQ));
                n_state  = lsmp_pkg::ST_FINISH;
            end
            lsmp_pkg::ST_FINISH: begin
                n_cell_y = lsmp_pkg::to_cells(r_prod);
                n_state  = r_keep ? lsmp_pkg::ST_OUT : lsmp_pkg::ST_IDLE;
            end
            lsmp_pkg::ST_OUT: begin
                if (!r_m_valid || m_axis_tready) begin
                    n_m_valid = 1'b1;
                    n_out_x   = r_cell_x;
                    n_out_y   = r_cell_y;
                    n_out_n   = r_idx;
                    n_state   = lsmp_pkg::ST_IDLE;
                end
            end
            default: n_state = lsmp_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= lsmp_pkg::ST_IDLE;
            r_beam_count <= '0;
            r_beam_angle <= '0;
            r_m_valid    <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_beam_count <= n_beam_count;
            r_beam_angle <= n_beam_angle;
            r_m_valid    <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod   <= mul_p;
        r_range  <= n_range;
        r_idx    <= n_idx;
        r_x      <= n_x;
        r_y      <= n_y;
        r_d2     <= n_d2;
        r_cell_x <= n_cell_x;
        r_cell_y <= n_cell_y;
        r_keep   <= n_keep;
        r_out_x  <= n_out_x;
        r_out_y  <= n_out_y;
        r_out_n  <= n_out_n;
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {4'd0, r_out_n, r_out_y, r_out_x};

endmodule
`default_nettype wire

FILE: design/lsmp_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lsmp_checker
// Port-level checks for the laser scan projection block, bound to its top.
// ----------------------------------------------------------------------------
module lsmp_checker #(
    parameter int MAX_BEAMS = 4096
) (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [47:0] m_axis_tdata
);

    // A stalled output word stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
        else $error("output word withdrawn while stalled");

    // A stalled output word keeps its value.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
        else $error("output word changed while stalled");

    // A new point is only produced at the end of a busy stretch of the sequencer.
    a_out_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> ($past(!s_axis_tready, 1) && $past(!s_axis_tready, 8)))
        else $error("point produced without a full computation");

    // The beam number stays below the configured scan length.
    a_beam_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (int'(m_axis_tdata[43:32]) < MAX_BEAMS))
        else $error("beam number out of range");

endmodule

bind laser_scan_to_map_points lsmp_checker #(
    .MAX_BEAMS (MAX_BEAMS)
) u_lsmp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire
